// ----- rtl/ctrr_pkg.sv -----
// Shared types and constants for the conversion task round-robin scheduler.
// Depends on nothing; every other file imports it.
package ctrr_pkg;

   localparam int TASK_SLOTS_DEFAULT = 8;
   localparam int ID_W               = 3;

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_FREE     = 2'd1;
   localparam logic [1:0] OP_COMPLETE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] task_id;
      logic [2:0] channel;
      logic [3:0] length;
      logic       multi;
      logic       scan;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] assigned_id;
      logic       done_valid;
      logic [2:0] done_task;
      logic       abort;
      logic       start_valid;
      logic [2:0] start_task;
      logic [2:0] start_channel;
      logic [3:0] start_length;
      logic       start_multi;
      logic       start_scan;
   } rsp_type;

   typedef struct packed {
      logic       scan;
      logic       multi;
      logic [3:0] length;
      logic [2:0] channel;
   } settings_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic status_full;
      logic scan_init_free;
      logic scan_init_next;
      logic scan_step;
      logic do_register;
      logic release_req;
      logic complete;
      logic pick;
      logic load_start;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       table_full;
      logic       ptr_used;
      logic       cur_valid;
      logic       sel_needed;
      logic       rsp_free;
   } stat_type;

endpackage

// ----- rtl/ctrr_dp.sv -----
// Datapath of the scheduler: slot table, settings memory, scan pointer,
// result assembly and the output register. Depends on ctrr_pkg.
module ctrr_dp
   import ctrr_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
   localparam int CMP_W  = ((SLOT_W > ID_W) ? SLOT_W : ID_W) + 1;

   logic [TASK_SLOTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic                  known_ff, known_in;
   logic                  running_ff, running_in;
   logic [SLOT_W-1:0]     ptr_ff, ptr_in;
   req_type               req_ff, req_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   settings_type          mem [TASK_SLOTS];
   settings_type          rdata_ff;
   logic [SLOT_W-1:0]     rd_addr;

   logic [CMP_W-1:0]      id_ext;
   logic                  id_ok;
   logic [SLOT_W-1:0]     id_idx;
   logic                  id_used;
   logic                  rel_en;
   logic [SLOT_W-1:0]     rel_idx;
   logic                  rel_match;
   logic [CNT_W-1:0]      count_dec;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      if (s == SLOT_W'(TASK_SLOTS - 1)) begin
         n = '0;
      end else begin
         n = s + 1'b1;
      end
      return n;
   endfunction

   assign id_ext    = CMP_W'(req_ff.task_id);
   assign id_ok     = id_ext < CMP_W'(TASK_SLOTS);
   assign id_idx    = SLOT_W'(id_ext);
   assign id_used   = id_ok && used_ff[id_idx];
   assign rel_idx   = cmd.release_req ? id_idx : cur_ff;
   assign rel_en    = (cmd.release_req && id_used) || (cmd.complete && !rdata_ff.scan);
   assign rel_match = known_ff && (cur_ff == rel_idx);
   assign count_dec = count_ff - 1'b1;
   assign rd_addr   = cmd.pick ? ptr_ff : cur_ff;

   always_comb begin
      used_in      = used_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      known_in     = known_ff;
      running_in   = running_ff;
      ptr_in       = ptr_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.latch_req) begin
         req_in = req_data;
         res_in = '0;
      end
      if (cmd.status_full) begin
         res_in.status = STATUS_FULL;
      end
      if (cmd.release_req && !id_used) begin
         res_in.status = STATUS_EMPTY;
      end
      if (rel_en) begin
         used_in[rel_idx] = 1'b0;
         count_in         = count_dec;
         if (rel_match) begin
            res_in.abort = 1'b1;
         end
         if ((count_dec != '0) || rel_match) begin
            running_in = 1'b0;
         end
      end
      if (cmd.complete) begin
         res_in.done_valid = 1'b1;
         res_in.done_task  = ID_W'(cur_ff);
      end
      if (cmd.do_register) begin
         used_in[ptr_ff]    = 1'b1;
         count_in           = count_ff + 1'b1;
         res_in.assigned_id = ID_W'(ptr_ff);
         // first task in the table starts at once
         if (count_ff == '0) begin
            cur_in               = ptr_ff;
            known_in             = 1'b1;
            running_in           = 1'b1;
            res_in.start_valid   = 1'b1;
            res_in.start_task    = ID_W'(ptr_ff);
            res_in.start_channel = req_ff.channel;
            res_in.start_length  = req_ff.length;
            res_in.start_multi   = req_ff.multi;
            res_in.start_scan    = req_ff.scan;
         end
      end
      if (cmd.scan_init_free) begin
         ptr_in = '0;
      end
      if (cmd.scan_init_next) begin
         ptr_in = next_slot(cur_ff);
      end
      if (cmd.scan_step) begin
         ptr_in = next_slot(ptr_ff);
      end
      if (cmd.pick) begin
         cur_in             = ptr_ff;
         known_in           = 1'b1;
         running_in         = 1'b1;
         res_in.start_valid = 1'b1;
         res_in.start_task  = ID_W'(ptr_ff);
      end
      if (cmd.load_start) begin
         res_in.start_channel = rdata_ff.channel;
         res_in.start_length  = rdata_ff.length;
         res_in.start_multi   = rdata_ff.multi;
         res_in.start_scan    = rdata_ff.scan;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         count_ff     <= '0;
         cur_ff       <= SLOT_W'(TASK_SLOTS - 1);
         known_ff     <= 1'b0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         known_ff     <= known_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // settings memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.do_register) begin
         mem[ptr_ff] <= '{scan: req_ff.scan, multi: req_ff.multi,
                          length: req_ff.length, channel: req_ff.channel};
      end
      rdata_ff <= mem[rd_addr];
   end

   assign stat.op         = req_ff.operation;
   assign stat.table_full = count_ff == CNT_W'(TASK_SLOTS);
   assign stat.ptr_used   = used_ff[ptr_ff];
   assign stat.cur_valid  = known_ff && used_ff[cur_ff];
   assign stat.sel_needed = (count_ff > CNT_W'(1)) || (!running_ff && (count_ff != '0));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/ctrr_ctrl.sv -----
// Controller state machine of the scheduler: sequences decode, slot scans,
// release, start and result hand-off. Depends on ctrr_pkg.
module ctrr_ctrl
   import ctrr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DECODE    = 8'b0000_0010,
      S_FREE_SCAN = 8'b0000_0100,
      S_COMPLETE  = 8'b0000_1000,
      S_SELECT    = 8'b0001_0000,
      S_NEXT_SCAN = 8'b0010_0000,
      S_START     = 8'b0100_0000,
      S_FINISH    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_REGISTER: begin
                  if (stat.table_full) begin
                     cmd.status_full = 1'b1;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.scan_init_free = 1'b1;
                     state_in           = S_FREE_SCAN;
                  end
               end
               OP_FREE: begin
                  cmd.release_req = 1'b1;
                  state_in        = S_SELECT;
               end
               OP_COMPLETE: begin
                  // settings of the current slot are read this cycle
                  state_in = stat.cur_valid ? S_COMPLETE : S_SELECT;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_FREE_SCAN: begin
            if (!stat.ptr_used) begin
               cmd.do_register = 1'b1;
               state_in        = S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_COMPLETE: begin
            cmd.complete = 1'b1;
            state_in     = S_SELECT;
         end
         S_SELECT: begin
            if (stat.sel_needed) begin
               cmd.scan_init_next = 1'b1;
               state_in           = S_NEXT_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_NEXT_SCAN: begin
            // a used slot always exists here, so the scan ends
            if (stat.ptr_used) begin
               cmd.pick = 1'b1;
               state_in = S_START;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_START: begin
            cmd.load_start = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register can take the item
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/conversion_task_round_robin_top.sv -----
// Channel  Handshake              Payload
// req      req_valid/req_ready    req_data  (ctrr_pkg::req_type)
// rsp      rsp_valid/rsp_ready    rsp_data  (ctrr_pkg::rsp_type)
// One item at a time. Register scans for the first free slot from index 0,
// and a full table skips that scan; free and complete pass through the
// round-robin scan that checks one slot a cycle.
// Reset is synchronous and empties the table. A new item is taken while a
// result waits in the output register; a stalled result holds the next one.
// Top level of the scheduler; instantiates ctrr_ctrl and ctrr_dp, uses ctrr_pkg.
module conversion_task_round_robin_top
   import ctrr_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   ctrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ctrr_dp #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
